FILE: rtl/core/motor_soft_ramp_reverser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor soft ramp reverser
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SOFT_RAMP_REVERSER_ASSERT_SVH
`define MOTOR_SOFT_RAMP_REVERSER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define MSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msr assertion failed");

`else

`define MSR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants of the motor soft ramp reverser.
// ----------------------------------------------------------------------------
package msr_pkg;

    // Default duty counter width.
    localparam int DUTY_WIDTH_DEFAULT = 8;

    // Reset values of the ramp interval register and the target duty.
    localparam logic [7:0] INTERVAL_RESET = 8'd10;
    localparam logic [7:0] TARGET_RESET   = 8'd10;

    // Configuration port: byte address bits and register index codes.
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_RAMP_INTERVAL = 1'b0;

    // Request kinds.
    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_START     = 3'd1,
        KIND_STOP      = 3'd2,
        KIND_REVERSE   = 3'd3,
        KIND_SET_SPEED = 3'd4
    } t_kind;

    // One input request.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] new_speed;
    } t_in_item;

    // One status result.
    typedef struct packed {
        logic [7:0] duty;
        logic       direction_ccw;
        logic       running;
        logic       reverse_pending;
        logic       ramp_active;
        logic [7:0] target;
    } t_out_item;

endpackage

FILE: rtl/core/msr_apb_cfg.sv
// ----------------------------------------------------------------------------
// msr_apb_cfg
// APB-style configuration register holding the ramp interval.
// ----------------------------------------------------------------------------
module msr_apb_cfg
    import msr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [7:0]            o_ramp_interval
);

    logic [7:0] r_ramp_interval;
    logic       wr_en;

    // The register index is the address bit above the word offset.
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1] == REG_RAMP_INTERVAL);
    assign pready = 1'b1;

    // Ramp interval register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_interval <= INTERVAL_RESET;
        end else if (wr_en) begin
            r_ramp_interval <= pwdata[7:0];
        end
    end

    // Read back; addresses past the register list read as zero.
    always_comb begin
        if (paddr[CFG_ADDR_W-1] == REG_RAMP_INTERVAL) begin
            prdata = {24'd0, r_ramp_interval};
        end else begin
            prdata = 32'd0;
        end
    end

    assign o_ramp_interval = r_ramp_interval;

endmodule

FILE: rtl/core/msr_ctrl.sv
// ----------------------------------------------------------------------------
// msr_ctrl
// Ramp controller state and its update for one request.
// ----------------------------------------------------------------------------
`include "motor_soft_ramp_reverser_assert.svh"

module msr_ctrl
    import msr_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    input  logic [7:0] i_ramp_interval,
    output t_out_item  o_result
);

    localparam logic [DUTY_WIDTH-1:0] DUTY_ONE = DUTY_WIDTH'(1);

    logic [DUTY_WIDTH-1:0] r_duty, n_duty;
    logic [DUTY_WIDTH-1:0] r_target, n_target;
    logic                  r_dir, n_dir;
    logic                  r_run, n_run;
    logic                  r_rev, n_rev;
    logic                  r_timer_on, n_timer_on;
    logic [7:0]            r_timer_left, n_timer_left;

    // Next state for the request held in the input register.
    always_comb begin
        n_duty       = r_duty;
        n_target     = r_target;
        n_dir        = r_dir;
        n_run        = r_run;
        n_rev        = r_rev;
        n_timer_on   = r_timer_on;
        n_timer_left = r_timer_left;
        unique case (i_item.kind)
            KIND_TICK: begin
                if (r_timer_on) begin
                    if (r_timer_left > 8'd1) begin
                        n_timer_left = r_timer_left - 8'd1;
                    end else if (r_run) begin
                        // Ramp step while running: reversal first winds down.
                        if (r_rev) begin
                            if (r_duty == '0) begin
                                n_dir = !r_dir;
                                n_rev = 1'b0;
                            end else begin
                                n_duty = r_duty - DUTY_ONE;
                            end
                        end else if (r_duty < r_target) begin
                            n_duty = r_duty + DUTY_ONE;
                        end
                        n_timer_left = i_ramp_interval;
                    end else if (r_duty != '0) begin
                        // Ramp step after a stop.
                        n_duty       = r_duty - DUTY_ONE;
                        n_timer_left = i_ramp_interval;
                    end else begin
                        n_timer_on = 1'b0;
                    end
                end
            end
            KIND_START: begin
                if (!r_run) begin
                    n_run        = 1'b1;
                    n_timer_on   = 1'b1;
                    n_timer_left = i_ramp_interval;
                end
            end
            KIND_STOP: begin
                n_run = 1'b0;
            end
            KIND_REVERSE: begin
                n_rev = 1'b1;
            end
            KIND_SET_SPEED: begin
                n_target = DUTY_WIDTH'(i_item.new_speed);
            end
            default: begin
            end
        endcase
    end

    // State registers advance once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty       <= '0;
            r_target     <= DUTY_WIDTH'(TARGET_RESET);
            r_dir        <= 1'b0;
            r_run        <= 1'b0;
            r_rev        <= 1'b0;
            r_timer_on   <= 1'b0;
            r_timer_left <= 8'd0;
        end else if (i_step) begin
            r_duty       <= n_duty;
            r_target     <= n_target;
            r_dir        <= n_dir;
            r_run        <= n_run;
            r_rev        <= n_rev;
            r_timer_on   <= n_timer_on;
            r_timer_left <= n_timer_left;
        end
    end

    // Status after the request has been applied.
    always_comb begin
        o_result.duty            = 8'(n_duty);
        o_result.direction_ccw   = n_dir;
        o_result.running         = n_run;
        o_result.reverse_pending = n_rev;
        o_result.ramp_active     = n_timer_on;
        o_result.target          = 8'(n_target);
    end

    // A tick with the timer off leaves the duty alone.
    `MSR_ASSERT_NEXT(a_idle_tick, i_clk, i_rst_n, i_step && (i_item.kind == KIND_TICK) && !r_timer_on, $stable(r_duty))

    // The duty moves by at most one per request.
    `MSR_ASSERT_NEXT(a_duty_step, i_clk, i_rst_n, i_step, (r_duty == $past(r_duty)) || (r_duty == $past(r_duty) + DUTY_ONE) || (r_duty == $past(r_duty) - DUTY_ONE))

    // Direction only flips at zero duty, and that completes the reversal.
    `MSR_ASSERT_IMP(a_flip_at_zero, i_clk, i_rst_n, r_dir != $past(r_dir), (r_duty == '0) && !r_rev)

endmodule

FILE: rtl/core/motor_soft_ramp_reverser.sv
// A request accepted into the input register has its result taken into the output
// register when that register is free or draining.
// Throughput: one request per cycle while i_out_ready does not stall the output.
// The input and output registers let a new request enter while a result waits.
// Reset (i_rst_n low, synchronous) clears both channels and the ramp state, sets the
// ramp interval to 10, and the target duty resets to 10.
// ----------------------------------------------------------------------------
// motor_soft_ramp_reverser
// Soft-start DC motor PWM duty controller with ramped direction reversal.
// ----------------------------------------------------------------------------
module motor_soft_ramp_reverser
    import msr_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       step;
    logic [7:0] ramp_interval;
    t_out_item  result;

    // A held request is processed when the output register is free or draining.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    msr_apb_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_ramp_interval (ramp_interval)
    );

    msr_ctrl #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_item          (r_in_item),
        .i_ramp_interval (ramp_interval),
        .o_result        (result)
    );

endmodule

FILE: tb/motor_soft_ramp_reverser_tb.sv
// ----------------------------------------------------------------------------
// motor_soft_ramp_reverser_tb
// Self-checking bench for the soft-ramp motor duty controller. Requests are
// fed from a queue by a clocked driver, and results are taken by a clocked
// monitor with random back-pressure. A behavioral model of the ramp timer,
// the duty ramp and the reversal sequence predicts every status word. The
// model is stepped as each request is accepted. The ramp interval is changed
// between phases through the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_soft_ramp_reverser_tb;
    import msr_pkg::*;

    // Request codes the enum leaves unnamed; the block must ignore them.
    localparam t_kind KIND_RESERVED_FIRST = t_kind'(3'd5);
    localparam t_kind KIND_RESERVED_LAST  = t_kind'(3'd7);

    localparam logic [CFG_ADDR_W-1:0] INTERVAL_ADDR =
        CFG_ADDR_W'(4 * int'(REG_RAMP_INTERVAL));

    localparam int MAX_GAP        = 17;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int CLIMB_TICKS    = 300;
    localparam int RANDOM_PER_SET = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Pacing controls set by the sequencing process.
    logic send_calm = 1'b0;
    logic recv_calm = 1'b0;
    logic out_hold  = 1'b0;

    t_in_item  pending_requests[$];
    t_out_item expected_status[$];
    int unsigned mismatch_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;

    // Model copy of the controller state and its ramp interval register.
    logic [7:0] m_interval   = INTERVAL_RESET;
    logic [7:0] m_duty       = '0;
    logic [7:0] m_target     = TARGET_RESET;
    logic       m_ccw        = 1'b0;
    logic       m_run        = 1'b0;
    logic       m_rev        = 1'b0;
    logic       m_timer_on   = 1'b0;
    logic [7:0] m_timer_left = '0;

    motor_soft_ramp_reverser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("[motor_soft_ramp_reverser] ERROR");
        $finish;
    end

    function automatic int unsigned draw_gap(input logic calm);
        if (calm || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic reload_ramp_timer();
        m_timer_on   = 1'b1;
        m_timer_left = m_interval;
    endtask

    // Apply one accepted request to the model and queue the status it yields.
    task automatic predict_status(input t_in_item req);
        t_out_item s;
        case (req.kind)
            KIND_TICK: begin
                if (m_timer_on) begin
                    if (m_timer_left > 8'd1) begin
                        m_timer_left = m_timer_left - 8'd1;
                    end else if (m_run) begin
                        // A pending reversal ramps down first, then flips.
                        if (m_rev) begin
                            if (m_duty == '0) begin
                                m_ccw = !m_ccw;
                                m_rev = 1'b0;
                            end else begin
                                m_duty = m_duty - 8'd1;
                            end
                        end else if (m_duty < m_target) begin
                            m_duty = m_duty + 8'd1;
                        end
                        reload_ramp_timer();
                    end else if (m_duty != '0) begin
                        m_duty = m_duty - 8'd1;
                        reload_ramp_timer();
                    end else begin
                        m_timer_on = 1'b0;
                    end
                end
            end
            KIND_START: begin
                if (!m_run) begin
                    m_run = 1'b1;
                    reload_ramp_timer();
                end
            end
            KIND_STOP:      m_run = 1'b0;
            KIND_REVERSE:   m_rev = 1'b1;
            KIND_SET_SPEED: m_target = req.new_speed;
            default: ;
        endcase
        s.duty            = m_duty;
        s.direction_ccw   = m_ccw;
        s.running         = m_run;
        s.reverse_pending = m_rev;
        s.ramp_active     = m_timer_on;
        s.target          = m_target;
        expected_status.push_back(s);
    endtask

    task automatic check_status(input t_out_item got);
        t_out_item want;
        if (expected_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("unexpected status: got %p", got);
            end
        end else begin
            want = expected_status.pop_front();
            if (got.duty !== want.duty || got.direction_ccw !== want.direction_ccw ||
                    got.running !== want.running ||
                    got.reverse_pending !== want.reverse_pending ||
                    got.ramp_active !== want.ramp_active || got.target !== want.target) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("status mismatch: expected %p, got %p", want, got);
                end
            end
        end
    endtask

    // Request driver: holds each request until accepted, then idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_status(i_in_item);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    i_in_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (pending_requests.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_requests.pop_front();
                    send_gap   <= draw_gap(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Status monitor: checks each accepted result and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_status(o_out_item);
            end
            if (out_hold) begin
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                if (draw_gap(recv_calm) != 0) begin
                    i_out_ready <= 1'b0;
                    recv_stall  <= $urandom_range(0, MAX_GAP - 1);
                end else begin
                    i_out_ready <= 1'b1;
                end
            end else if (recv_stall != 0) begin
                i_out_ready <= 1'b0;
                recv_stall  <= recv_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push_request(input t_kind kind, input logic [7:0] speed);
        t_in_item r;
        r.kind      = kind;
        r.new_speed = speed;
        pending_requests.push_back(r);
    endtask

    // Mostly ticks, so that the ramp timer actually advances the duty.
    task automatic push_random_request();
        int unsigned pick;
        logic [7:0] speed;
        pick  = $urandom_range(0, 99);
        speed = 8'($urandom_range(0, 255));
        if (pick < 70) begin
            push_request(KIND_TICK, speed);
        end else if (pick < 76) begin
            push_request(KIND_START, speed);
        end else if (pick < 80) begin
            push_request(KIND_STOP, speed);
        end else if (pick < 85) begin
            push_request(KIND_REVERSE, speed);
        end else if (pick < 96) begin
            push_request(KIND_SET_SPEED, speed);
        end else begin
            push_request(t_kind'($urandom_range(KIND_RESERVED_FIRST, KIND_RESERVED_LAST)),
                speed);
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || i_in_valid ||
            expected_status.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write of the ramp interval, followed by a read-back.
    task automatic write_interval(input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INTERVAL_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
        end while (!pready);
        @(posedge i_clk);
        m_interval = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
        end while (!pready);
        if (prdata[7:0] !== value) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("interval read-back: expected %0d, got %0d", value, prdata[7:0]);
            end
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] intervals[6];
        intervals = '{8'd255, 8'd0, 8'd2, 8'd3, 8'd1, 8'd4};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests at the reset interval: idle tick, reserved codes,
        // target extremes, reversal while stopped, start while running, and a
        // reversal that completes at zero duty.
        push_request(KIND_TICK, 8'hFF);
        push_request(KIND_RESERVED_FIRST, 8'h00);
        push_request(KIND_SET_SPEED, 8'hFF);
        push_request(KIND_SET_SPEED, 8'h00);
        push_request(KIND_REVERSE, 8'h5A);
        push_request(KIND_START, 8'hA5);
        push_request(KIND_START, 8'h00);
        repeat (11) push_request(KIND_TICK, 8'h00);
        push_request(KIND_SET_SPEED, 8'd3);
        push_request(t_kind'(3'd6), 8'hFF);
        push_request(KIND_RESERVED_LAST, 8'hFF);
        push_request(KIND_STOP, 8'h00);
        push_request(KIND_REVERSE, 8'h00);
        push_request(KIND_TICK, 8'h00);
        wait_drained();

        // Fast ramp to full duty, with a lowered target partway through.
        write_interval(8'd1);
        send_calm <= 1'b1;
        recv_calm <= 1'b1;
        push_request(KIND_SET_SPEED, 8'hFF);
        push_request(KIND_STOP, 8'h00);
        push_request(KIND_START, 8'h00);
        for (int i = 0; i < CLIMB_TICKS; i++) begin
            if (i == 100) begin
                push_request(KIND_SET_SPEED, 8'd20);
            end else if (i == 110) begin
                push_request(KIND_SET_SPEED, 8'hFF);
            end else begin
                push_request(KIND_TICK, 8'($urandom_range(0, 255)));
            end
        end
        wait_drained();

        // Random phases over several ramp intervals, extremes included.
        foreach (intervals[p]) begin
            write_interval(intervals[p]);
            send_calm <= ($urandom_range(0, 3) == 0);
            recv_calm <= ($urandom_range(0, 3) == 0);
            repeat (RANDOM_PER_SET) push_random_request();
            if (p == 2) begin
                // Block the result channel long enough to back up the input.
                @(posedge i_clk);
                out_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_hold <= 1'b0;
            end
            wait_drained();
        end

        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("[motor_soft_ramp_reverser] OK");
        end else begin
            $display("[motor_soft_ramp_reverser] ERROR");
        end
        $finish;
    end

endmodule
